>>> hw/rtl/tail_drop_output_queue_top_assert.svh
// assertion macros used by the queue back end rtl
`ifndef TAIL_DROP_OUTPUT_QUEUE_TOP_ASSERT_SVH
`define TAIL_DROP_OUTPUT_QUEUE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TDOQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdoq check failed");

// consequent checked in the cycle after the antecedent
`define TDOQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdoq check failed");

`endif

>>> hw/rtl/tdoq_pkg.sv
// shared constants, codes and types of the tail drop output queue
package tdoq_pkg;

   // queue storage
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int CMD_W     = 1;
   localparam int TAG_W     = 16;
   localparam int SIZE_W    = 16;
   localparam int TIME_W    = 48;
   localparam int RATE_W    = 32;
   localparam int LIMIT_W   = 7;
   localparam int TOTAL_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int OCC_W     = 7;
   localparam int ENTRY_W   = TAG_W + SIZE_W + TIME_W;
   localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // divider: (size << 32) / rate, one quotient bit per cycle
   localparam int DIV_SHIFT = 32;
   localparam int QUOT_W    = SIZE_W + DIV_SHIFT;
   localparam int REM_W     = RATE_W + 1;
   localparam int STEP_W    = $clog2(QUOT_W);

   // job queue between front and back
   localparam int JOBQ_DEPTH = 2;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_RATE   = 2'd1;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 7'd64;
   localparam logic [RATE_W-1:0]    RATE_RESET      = 32'd65536;

   // commands
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_SWITCH  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SWITCHED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 3'd4;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // classified item handed from front to back
   typedef struct packed {
      logic              is_switch;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] stamp;   // arrival time on enqueue, current time on switch
   } job_type;

   // one stored queue entry
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] ready_time;
   } entry_type;

   // one result word
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    out_tag;
      logic [SIZE_W-1:0]   out_size;
      logic [TIME_W-1:0]   out_ready_time;
      logic [TOTAL_W-1:0]  dropped_count;
      logic [TOTAL_W-1:0]  transmitted_count;
      logic [OCC_W-1:0]    occupancy;
   } result_type;

endpackage

>>> hw/rtl/tdoq_ifs.sv
// request, response and configuration channel interfaces

// request channel
interface tdoq_req_if;
   logic                        valid;
   logic                        ready;
   logic [tdoq_pkg::CMD_W-1:0]  command;
   logic [tdoq_pkg::TAG_W-1:0]  packet_tag;
   logic [tdoq_pkg::SIZE_W-1:0] packet_size;
   logic [tdoq_pkg::TIME_W-1:0] arrival_time;
   logic [tdoq_pkg::TIME_W-1:0] current_time;

   modport source (output valid, command, packet_tag, packet_size, arrival_time,
                   current_time, input ready);
   modport sink   (input valid, command, packet_tag, packet_size, arrival_time,
                   current_time, output ready);
endinterface

// response channel
interface tdoq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tdoq_pkg::STATUS_W-1:0] status;
   logic [tdoq_pkg::TAG_W-1:0]    out_tag;
   logic [tdoq_pkg::SIZE_W-1:0]   out_size;
   logic [tdoq_pkg::TIME_W-1:0]   out_ready_time;
   logic [tdoq_pkg::TOTAL_W-1:0]  dropped_count;
   logic [tdoq_pkg::TOTAL_W-1:0]  transmitted_count;
   logic [tdoq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_tag, out_size, out_ready_time,
                   dropped_count, transmitted_count, occupancy, input ready);
   modport sink   (input valid, status, out_tag, out_size, out_ready_time,
                   dropped_count, transmitted_count, occupancy, output ready);
endinterface

// configuration write channel
interface tdoq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tdoq_pkg::CSR_IDX_W-1:0]  index;
   logic [tdoq_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tail_drop_output_queue_top.sv
// Tail-drop output queue of a router port, 64 entries.
// Channels: req_ch carries one command word (enqueue or switch out the head),
// rsp_ch returns exactly one result word per request, in order, and csr_ch
// writes the occupancy limit (index 0) or the Q16.16 link rate (index 1).
// csr_ch is always ready; write it only while no request is in flight.
// A request passes a one-word input stage and a two-word job queue, then the
// back end handles one job at a time.
// Steps per item in the back end: a stored enqueue takes a pop, 48 steps of the
// bit-serial restoring divider for size * 2^32 / rate, one add and RAM write and
// a result step; with a zero rate the divider is skipped. Drops and empty switches
// go from the pop straight to the result step; switches take one RAM read for
// the head entry in between. The back end takes no new job until the result of
// the last one is in the output register.
// Reset (synchronous) empties the queue, clears both counters and restores
// limit 64 and rate 1.0; the entry RAM is not cleared and needs no pass.
// When the receiver stalls, the result stays in the output register, the
// back end waits, and the job queue and input stage fill before req_ch.ready
// falls.
module tail_drop_output_queue_top (
   input  logic         clock,
   input  logic         reset,
   tdoq_req_if.sink     req_ch,
   tdoq_rsp_if.source   rsp_ch,
   tdoq_csr_if.sink     csr_ch
);

   logic              push_valid;
   logic              push_ready;
   tdoq_pkg::job_type push_job;
   logic              pop_valid;
   logic              pop_ready;
   tdoq_pkg::job_type pop_job;

   // request intake and classification
   tdoq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // job queue
   tdoq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // queue state, divider and results
   tdoq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ch),
      .rsp       (rsp_ch),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job)
   );

endmodule

>>> hw/rtl/tdoq_ram.sv
// generic single write port ram with registered read
module tdoq_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/tdoq_front.sv
// front end: takes request words and classifies them into jobs
module tdoq_front (
   input  logic              clock,
   input  logic              reset,
   tdoq_req_if.sink          req,
   output logic              push_valid,
   input  logic              push_ready,
   output tdoq_pkg::job_type push_job
);

   logic              hold_valid_ff;
   logic              hold_valid_in;
   tdoq_pkg::job_type hold_job_ff;
   tdoq_pkg::job_type hold_job_in;

   // stage frees when empty or when its job moves on
   assign req.ready = !hold_valid_ff || push_ready;

   // classify: pick the time stamp that the command needs
   always_comb begin
      hold_job_in.is_switch = (req.command == tdoq_pkg::CMD_SWITCH);
      hold_job_in.tag       = req.packet_tag;
      hold_job_in.size      = req.packet_size;
      hold_job_in.stamp     = (req.command == tdoq_pkg::CMD_SWITCH) ? req.current_time
                                                                    : req.arrival_time;
      hold_valid_in         = req.ready ? req.valid : hold_valid_ff;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         hold_job_ff <= hold_job_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_job   = hold_job_ff;

endmodule

>>> hw/rtl/tdoq_fifo.sv
// short job queue between front and back
module tdoq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tdoq_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tdoq_pkg::job_type pop_job
);

   tdoq_pkg::job_type                   slot_ff [tdoq_pkg::JOBQ_DEPTH];
   logic [tdoq_pkg::JOBQ_PTR_W-1:0]     wr_ptr_ff;
   logic [tdoq_pkg::JOBQ_PTR_W-1:0]     wr_ptr_in;
   logic [tdoq_pkg::JOBQ_PTR_W-1:0]     rd_ptr_ff;
   logic [tdoq_pkg::JOBQ_PTR_W-1:0]     rd_ptr_in;
   logic [tdoq_pkg::JOBQ_CNT_W-1:0]     fill_ff;
   logic [tdoq_pkg::JOBQ_CNT_W-1:0]     fill_in;
   logic                                do_push;
   logic                                do_pop;

   function automatic logic [tdoq_pkg::JOBQ_PTR_W-1:0] bump(
      input logic [tdoq_pkg::JOBQ_PTR_W-1:0] p
   );
      return (p == tdoq_pkg::JOBQ_PTR_W'(tdoq_pkg::JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (fill_ff != tdoq_pkg::JOBQ_CNT_W'(tdoq_pkg::JOBQ_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/tdoq_back.sv
// back end: queue state, serial divider, entry ram and result register
`include "tail_drop_output_queue_top_assert.svh"

module tdoq_back (
   input  logic              clock,
   input  logic              reset,
   tdoq_csr_if.sink          csr,
   tdoq_rsp_if.source        rsp,
   input  logic              job_valid,
   output logic              job_ready,
   input  tdoq_pkg::job_type job
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   // configuration
   logic [tdoq_pkg::LIMIT_W-1:0]  limit_cfg_ff;
   logic [tdoq_pkg::LIMIT_W-1:0]  limit_cfg_in;
   logic [tdoq_pkg::RATE_W-1:0]   rate_ff;
   logic [tdoq_pkg::RATE_W-1:0]   rate_in;

   // sequencer and queue state
   logic [2:0]                    state_ff;
   logic [2:0]                    state_in;
   tdoq_pkg::job_type             job_ff;
   tdoq_pkg::job_type             job_in;
   logic [tdoq_pkg::PTR_W-1:0]    head_ff;
   logic [tdoq_pkg::PTR_W-1:0]    head_in;
   logic [tdoq_pkg::PTR_W-1:0]    tail_ff;
   logic [tdoq_pkg::PTR_W-1:0]    tail_in;
   logic [tdoq_pkg::CNT_W-1:0]    count_ff;
   logic [tdoq_pkg::CNT_W-1:0]    count_in;
   logic [tdoq_pkg::TOTAL_W-1:0]  drop_ff;
   logic [tdoq_pkg::TOTAL_W-1:0]  drop_in;
   logic [tdoq_pkg::TOTAL_W-1:0]  xmit_ff;
   logic [tdoq_pkg::TOTAL_W-1:0]  xmit_in;

   // divider
   logic [tdoq_pkg::REM_W-1:0]    rem_ff;
   logic [tdoq_pkg::REM_W-1:0]    rem_in;
   logic [tdoq_pkg::QUOT_W-1:0]   quot_ff;
   logic [tdoq_pkg::QUOT_W-1:0]   quot_in;
   logic [tdoq_pkg::STEP_W-1:0]   step_ff;
   logic [tdoq_pkg::STEP_W-1:0]   step_in;
   logic [tdoq_pkg::REM_W-1:0]    rem_shift;
   logic [tdoq_pkg::REM_W-1:0]    rate_ext;

   // pending result
   logic [tdoq_pkg::STATUS_W-1:0] res_status_ff;
   logic [tdoq_pkg::STATUS_W-1:0] res_status_in;
   logic [tdoq_pkg::TAG_W-1:0]    res_tag_ff;
   logic [tdoq_pkg::TAG_W-1:0]    res_tag_in;
   logic [tdoq_pkg::SIZE_W-1:0]   res_size_ff;
   logic [tdoq_pkg::SIZE_W-1:0]   res_size_in;
   logic [tdoq_pkg::TIME_W-1:0]   res_time_ff;
   logic [tdoq_pkg::TIME_W-1:0]   res_time_in;

   // output register
   logic                          out_valid_ff;
   logic                          out_valid_in;
   tdoq_pkg::result_type          out_ff;
   tdoq_pkg::result_type          out_in;

   // misc datapath
   logic [tdoq_pkg::CMP_W-1:0]    limit_eff;
   logic                          has_room;
   logic [tdoq_pkg::TIME_W:0]     sum_ext;
   logic [tdoq_pkg::TIME_W-1:0]   ready_sat;
   tdoq_pkg::entry_type           wr_entry;
   tdoq_pkg::entry_type           rd_entry;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [tdoq_pkg::ENTRY_W-1:0]  ram_rd_data;

   function automatic logic [tdoq_pkg::PTR_W-1:0] next_slot(
      input logic [tdoq_pkg::PTR_W-1:0] p
   );
      return (p == tdoq_pkg::PTR_W'(tdoq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // configuration writes, taken at any time
   assign csr.ready = 1'b1;

   always_comb begin
      limit_cfg_in = limit_cfg_ff;
      rate_in      = rate_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            tdoq_pkg::CSR_MAX_ENTRIES: limit_cfg_in = csr.data[tdoq_pkg::LIMIT_W-1:0];
            tdoq_pkg::CSR_LINK_RATE:   rate_in      = csr.data[tdoq_pkg::RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // limit clamped to the queue depth
   always_comb begin
      if (tdoq_pkg::CMP_W'(limit_cfg_ff) > tdoq_pkg::CMP_W'(tdoq_pkg::QUEUE_DEPTH)) begin
         limit_eff = tdoq_pkg::CMP_W'(tdoq_pkg::QUEUE_DEPTH);
      end else begin
         limit_eff = tdoq_pkg::CMP_W'(limit_cfg_ff);
      end
      has_room = (tdoq_pkg::CMP_W'(count_ff) < limit_eff);
   end

   // divider step and saturating ready time
   always_comb begin
      rate_ext  = {1'b0, rate_ff};
      rem_shift = {rem_ff[tdoq_pkg::REM_W-2:0], quot_ff[tdoq_pkg::QUOT_W-1]};
      sum_ext   = {1'b0, job_ff.stamp} + {1'b0, quot_ff};
      ready_sat = sum_ext[tdoq_pkg::TIME_W] ? tdoq_pkg::TIME_MAX
                                            : sum_ext[tdoq_pkg::TIME_W-1:0];
      wr_entry.tag        = job_ff.tag;
      wr_entry.size       = job_ff.size;
      wr_entry.ready_time = ready_sat;
      rd_entry            = tdoq_pkg::entry_type'(ram_rd_data);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      xmit_in       = xmit_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_size_in   = res_size_ff;
      res_time_in   = res_time_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      job_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in = job;
               if (!job.is_switch) begin
                  if (has_room) begin
                     if (rate_ff == '0) begin
                        // zero rate: all-ones delay saturates the sum
                        quot_in  = '1;
                        state_in = ST_ADD;
                     end else begin
                        rem_in   = '0;
                        quot_in  = {job.size, {tdoq_pkg::DIV_SHIFT{1'b0}}};
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end else begin
                     drop_in       = drop_ff + 1'b1;
                     res_status_in = tdoq_pkg::STATUS_DROPPED;
                     res_tag_in    = '0;
                     res_size_in   = '0;
                     res_time_in   = '0;
                     state_in      = ST_EMIT;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = tdoq_pkg::STATUS_EMPTY;
                  res_tag_in    = '0;
                  res_size_in   = '0;
                  res_time_in   = '0;
                  state_in      = ST_EMIT;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rem_shift >= rate_ext) begin
               rem_in  = rem_shift - rate_ext;
               quot_in = {quot_ff[tdoq_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               quot_in = {quot_ff[tdoq_pkg::QUOT_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == tdoq_pkg::STEP_W'(tdoq_pkg::QUOT_W - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ram_wr_en     = 1'b1;
            tail_in       = next_slot(tail_ff);
            count_in      = count_ff + 1'b1;
            res_status_in = tdoq_pkg::STATUS_ENQUEUED;
            res_tag_in    = '0;
            res_size_in   = '0;
            res_time_in   = ready_sat;
            state_in      = ST_EMIT;
         end
         ST_READ: begin
            if (rd_entry.ready_time > job_ff.stamp) begin
               res_status_in = tdoq_pkg::STATUS_NOT_READY;
               res_tag_in    = '0;
               res_size_in   = '0;
               res_time_in   = '0;
            end else begin
               res_status_in = tdoq_pkg::STATUS_SWITCHED;
               res_tag_in    = rd_entry.tag;
               res_size_in   = rd_entry.size;
               res_time_in   = rd_entry.ready_time;
               head_in       = next_slot(head_ff);
               count_in      = count_ff - 1'b1;
               xmit_in       = xmit_ff + 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in             = 1'b1;
               out_in.status            = res_status_ff;
               out_in.out_tag           = res_tag_ff;
               out_in.out_size          = res_size_ff;
               out_in.out_ready_time    = res_time_ff;
               out_in.dropped_count     = drop_ff;
               out_in.transmitted_count = xmit_ff;
               out_in.occupancy         = tdoq_pkg::OCC_W'(count_ff);
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_cfg_ff <= tdoq_pkg::LIMIT_RESET;
         rate_ff      <= tdoq_pkg::RATE_RESET;
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         drop_ff      <= '0;
         xmit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_cfg_ff <= limit_cfg_in;
         rate_ff      <= rate_in;
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         xmit_ff      <= xmit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_size_ff   <= res_size_in;
      res_time_ff   <= res_time_in;
      out_ff        <= out_in;
   end

   // entry storage
   tdoq_ram #(
      .WIDTH (tdoq_pkg::ENTRY_W),
      .DEPTH (tdoq_pkg::QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // response channel
   assign rsp.valid             = out_valid_ff;
   assign rsp.status            = out_ff.status;
   assign rsp.out_tag           = out_ff.out_tag;
   assign rsp.out_size          = out_ff.out_size;
   assign rsp.out_ready_time    = out_ff.out_ready_time;
   assign rsp.dropped_count     = out_ff.dropped_count;
   assign rsp.transmitted_count = out_ff.transmitted_count;
   assign rsp.occupancy         = out_ff.occupancy;

   // checks
   `TDOQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= tdoq_pkg::CNT_W'(tdoq_pkg::QUEUE_DEPTH))
   `TDOQ_ASSERT_NEXT(a_enq_count, clock, reset, state_ff == ST_ADD,
      count_ff == $past(count_ff) + tdoq_pkg::CNT_W'(1))
   `TDOQ_ASSERT_SAME(a_div_steps, clock, reset, state_ff == ST_DIV,
      step_ff <= tdoq_pkg::STEP_W'(tdoq_pkg::QUOT_W - 1))
   `TDOQ_ASSERT_SAME(a_rsp_source, clock, reset, $rose(out_valid_ff),
      $past(state_ff) == ST_EMIT)

endmodule

>>> tb/sv/tb_tail_drop_output_queue_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the tail drop output queue: directed rows, then random phases
module tb_tail_drop_output_queue_top;
   import tdoq_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_WORDS = 550;
   localparam int CALM_WORDS   = 100;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // one row of the directed stimulus
   typedef struct {
      row_kind_type          kind;
      logic [CMD_W-1:0]      command;
      logic [TAG_W-1:0]      tag;
      logic [SIZE_W-1:0]     size;
      logic [TIME_W-1:0]     arrival;
      logic [TIME_W-1:0]     now;
      bit                    typed;
      result_type            want;
      logic [CSR_IDX_W-1:0]  csr_index;
      logic [CSR_DATA_W-1:0] csr_data;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   tdoq_req_if req_ch ();
   tdoq_rsp_if rsp_ch ();
   tdoq_csr_if csr_ch ();

   tail_drop_output_queue_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // queue contents and registers as the block should hold them
   logic [TAG_W-1:0]   held_tags  [QUEUE_DEPTH];
   logic [SIZE_W-1:0]  held_sizes [QUEUE_DEPTH];
   logic [TIME_W-1:0]  held_ready [QUEUE_DEPTH];
   logic [PTR_W-1:0]   held_head;
   logic [PTR_W-1:0]   held_tail;
   int unsigned        held_count;
   logic [TOTAL_W-1:0] drop_total;
   logic [TOTAL_W-1:0] transmit_total;
   logic [LIMIT_W-1:0] limit_reg;
   logic [RATE_W-1:0]  rate_reg;

   result_type    awaited_results [$];
   stim_row_type  stim_rows [$];
   int unsigned errors;
   int unsigned results_seen;
   int unsigned cycles;
   int unsigned req_gap_odds;
   int unsigned rsp_stall_odds;
   int unsigned rsp_stall_left;
   bit          req_up;
   bit          csr_up;
   logic [TIME_W-1:0] wall_time;

   task automatic report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   results_seen, name, got, want));
   endtask

   function automatic result_type result_of(logic [STATUS_W-1:0] status,
                                            logic [TAG_W-1:0] tag,
                                            logic [SIZE_W-1:0] size,
                                            logic [TIME_W-1:0] ready,
                                            int unsigned drops,
                                            int unsigned sent,
                                            int unsigned occ);
      result_type r;
      r.status            = status;
      r.out_tag           = tag;
      r.out_size          = size;
      r.out_ready_time    = ready;
      r.dropped_count     = TOTAL_W'(drops);
      r.transmitted_count = TOTAL_W'(sent);
      r.occupancy         = OCC_W'(occ);
      return r;
   endfunction

   // next slot of the held queue, wrapping at the depth
   function automatic logic [PTR_W-1:0] held_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // arrival plus size over rate, saturating; zero rate means never ready
   function automatic logic [TIME_W-1:0] departure_time(logic [TIME_W-1:0] arrival,
                                                        logic [SIZE_W-1:0] size);
      logic [63:0] delay;
      logic [63:0] total;
      if (rate_reg == '0) return TIME_MAX;
      delay = {16'h0, size, 32'h0} / {32'h0, rate_reg};
      total = {16'h0, arrival} + delay;
      return (total > {16'h0, TIME_MAX}) ? TIME_MAX : total[TIME_W-1:0];
   endfunction

   // apply one command to the held queue and return the word it yields
   function automatic result_type queue_outcome(logic [CMD_W-1:0] cmd,
                                                logic [TAG_W-1:0] tag,
                                                logic [SIZE_W-1:0] size,
                                                logic [TIME_W-1:0] arrival,
                                                logic [TIME_W-1:0] now);
      result_type  r;
      int unsigned cap;
      r   = '0;
      cap = (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : limit_reg;
      if (cmd == CMD_ENQUEUE) begin
         if (held_count < cap) begin
            r.out_ready_time      = departure_time(arrival, size);
            held_tags[held_tail]  = tag;
            held_sizes[held_tail] = size;
            held_ready[held_tail] = r.out_ready_time;
            held_tail             = held_next(held_tail);
            held_count++;
            r.status = STATUS_ENQUEUED;
         end else begin
            drop_total++;
            r.status = STATUS_DROPPED;
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
      end else if (held_ready[held_head] > now) begin
         r.status = STATUS_NOT_READY;
      end else begin
         r.out_tag        = held_tags[held_head];
         r.out_size       = held_sizes[held_head];
         r.out_ready_time = held_ready[held_head];
         held_head        = held_next(held_head);
         held_count--;
         transmit_total++;
         r.status = STATUS_SWITCHED;
      end
      r.dropped_count     = drop_total;
      r.transmitted_count = transmit_total;
      r.occupancy         = held_count[OCC_W-1:0];
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] any_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TIME_W-1:0];
   endfunction

   function automatic void add_word(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                                    logic [SIZE_W-1:0] size, logic [TIME_W-1:0] arrival,
                                    logic [TIME_W-1:0] now, bit typed = 1'b0,
                                    result_type want = '0);
      stim_row_type r;
      r.kind      = ROW_WORD;
      r.command   = cmd;
      r.tag       = tag;
      r.size      = size;
      r.arrival   = arrival;
      r.now       = now;
      r.typed     = typed;
      r.want      = want;
      r.csr_index = '0;
      r.csr_data  = '0;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r.kind      = ROW_CSR;
      r.command   = CMD_ENQUEUE;
      r.tag       = '0;
      r.size      = '0;
      r.arrival   = '0;
      r.now       = '0;
      r.typed     = 1'b0;
      r.want      = '0;
      r.csr_index = idx;
      r.csr_data  = data;
      stim_rows.push_back(r);
   endfunction

   // offer one request word, optionally after a gap, and record what it should yield
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                            logic [SIZE_W-1:0] size, logic [TIME_W-1:0] arrival,
                            logic [TIME_W-1:0] now, bit typed, result_type want);
      int unsigned gap;
      result_type  predicted;
      if (csr_up) begin
         csr_ch.valid <= 1'b0;
         csr_up = 1'b0;
      end
      gap = (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) ?
            $urandom_range(1, 16) : 0;
      if (gap != 0) begin
         if (req_up) req_ch.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.packet_tag   <= tag;
      req_ch.packet_size  <= size;
      req_ch.arrival_time <= arrival;
      req_ch.current_time <= now;
      req_up = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = queue_outcome(cmd, tag, size, arrival, now);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   // register write, only once every result is back
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (req_up) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (awaited_results.size() != 0) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      csr_up = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (idx == CSR_MAX_ENTRIES) limit_reg = data[LIMIT_W-1:0];
      else if (idx == CSR_LINK_RATE) rate_reg = data;
   endtask

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
         rsp_stall_left = $urandom_range(0, 15);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // compare each result word with the oldest one awaited
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none awaited", results_seen));
         end else begin
            want = awaited_results.pop_front();
            check_field("status", rsp_ch.status, want.status);
            check_field("out_tag", rsp_ch.out_tag, want.out_tag);
            check_field("out_size", rsp_ch.out_size, want.out_size);
            check_field("out_ready_time", rsp_ch.out_ready_time, want.out_ready_time);
            check_field("dropped_count", rsp_ch.dropped_count, want.dropped_count);
            check_field("transmitted_count", rsp_ch.transmitted_count,
                        want.transmitted_count);
            check_field("occupancy", rsp_ch.occupancy, want.occupancy);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_tail_drop_output_queue_top: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned       random_sent;
      int unsigned       phase_len;
      int unsigned       enq_pct;
      bit                calm;
      logic [CMD_W-1:0]  cmd;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] head_ready;
      logic [LIMIT_W-1:0] lim;
      logic [CSR_DATA_W-1:0] data;

      // every request and register input known from the start
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.command      <= CMD_ENQUEUE;
      req_ch.packet_tag   <= '0;
      req_ch.packet_size  <= '0;
      req_ch.arrival_time <= '0;
      req_ch.current_time <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_MAX_ENTRIES;
      csr_ch.data         <= '0;

      held_head      = '0;
      held_tail      = '0;
      held_count     = 0;
      drop_total     = '0;
      transmit_total = '0;
      limit_reg      = LIMIT_RESET;
      rate_reg       = RATE_RESET;
      wall_time      = '0;
      random_sent    = 0;

      // directed rows: empty queue, extremes, saturation, limits, spare indexes
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, '0, 1'b1,
               result_of(STATUS_EMPTY, '0, '0, '0, 0, 0, 0));
      add_word(CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, '0, TIME_MAX, 1'b1,
               result_of(STATUS_ENQUEUED, '0, '0, 48'h0000_FFFF_0000, 0, 0, 1));
      add_word(CMD_SWITCH, 16'hFFFF, 16'hFFFF, TIME_MAX, '0, 1'b1,
               result_of(STATUS_NOT_READY, '0, '0, '0, 0, 0, 1));
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX, 1'b1,
               result_of(STATUS_SWITCHED, 16'hFFFF, 16'hFFFF, 48'h0000_FFFF_0000, 0, 1, 0));
      add_word(CMD_ENQUEUE, 16'h0000, 16'h0000, TIME_MAX, '0, 1'b1,
               result_of(STATUS_ENQUEUED, '0, '0, TIME_MAX, 0, 1, 1));
      // ready time overflows and saturates
      add_word(CMD_ENQUEUE, 16'h1234, 16'hFFFF, 48'hFFFF_FFFF_0000, '0);
      add_word(CMD_SWITCH, 16'h0F0F, 16'hF0F0, '0, TIME_MAX - 1);
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX);
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX);
      // zero rate means the delay never ends
      add_write(CSR_LINK_RATE, 32'h0000_0000);
      add_word(CMD_ENQUEUE, 16'hC3C3, 16'h0000, '0, '0, 1'b1,
               result_of(STATUS_ENQUEUED, '0, '0, TIME_MAX, 0, 3, 1));
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX);
      // slowest and fastest links
      add_write(CSR_LINK_RATE, 32'h0000_0001);
      add_word(CMD_ENQUEUE, 16'h00FF, 16'h0001, 48'h0000_0000_0005, '0);
      add_word(CMD_ENQUEUE, 16'hFF00, 16'hFFFF, 48'h8000_0000_0000, '0);
      add_write(CSR_LINK_RATE, 32'hFFFF_FFFF);
      add_word(CMD_ENQUEUE, 16'hA5A5, 16'hFFFF, '0, '0);
      // zero limit drops everything
      add_write(CSR_MAX_ENTRIES, 32'h0000_0000);
      add_word(CMD_ENQUEUE, 16'h5A5A, 16'h8000, '0, '0, 1'b1,
               result_of(STATUS_DROPPED, '0, '0, '0, 1, 4, 3));
      // limit below the present occupancy
      add_write(CSR_MAX_ENTRIES, 32'h0000_0002);
      add_word(CMD_ENQUEUE, 16'h6666, 16'h0010, '0, '0, 1'b1,
               result_of(STATUS_DROPPED, '0, '0, '0, 2, 4, 3));
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX);
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX);
      add_word(CMD_ENQUEUE, 16'h7777, 16'h0100, 48'h0000_0001_0000, '0);
      add_word(CMD_ENQUEUE, 16'h8888, 16'h0200, '0, '0, 1'b1,
               result_of(STATUS_DROPPED, '0, '0, '0, 3, 6, 2));
      // limit above the depth, upper data bits set, then writes to spare indexes
      add_write(CSR_MAX_ENTRIES, 32'hFFFF_FF7F);
      add_write(CSR_SPARE_2, 32'h0000_0000);
      add_write(CSR_SPARE_3, 32'h0000_0000);
      add_word(CMD_ENQUEUE, 16'h4321, 16'h0040, 48'h0000_1234_5678, '0);
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, '0);
      add_word(CMD_SWITCH, 16'h0000, 16'h0000, '0, TIME_MAX);
      add_write(CSR_MAX_ENTRIES, {25'h0, LIMIT_RESET});
      add_write(CSR_LINK_RATE, RATE_RESET);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the directed rows
      req_gap_odds   = 4;
      rsp_stall_odds = 4;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_register(stim_rows[i].csr_index, stim_rows[i].csr_data);
         else
            send_word(stim_rows[i].command, stim_rows[i].tag, stim_rows[i].size,
                      stim_rows[i].arrival, stim_rows[i].now, stim_rows[i].typed,
                      stim_rows[i].want);
      end

      // random phases, each with its own limit, rate, traffic mix and idling
      while (random_sent < RANDOM_WORDS) begin
         calm = (random_sent + CALM_WORDS >= RANDOM_WORDS);
         case ($urandom_range(0, 2))
            0:       req_gap_odds = 0;
            1:       req_gap_odds = 3;
            default: req_gap_odds = 10;
         endcase
         case ($urandom_range(0, 2))
            0:       rsp_stall_odds = 0;
            1:       rsp_stall_odds = 3;
            default: rsp_stall_odds = 10;
         endcase
         if (calm) begin
            req_gap_odds   = 0;
            rsp_stall_odds = 0;
         end

         case ($urandom_range(0, 7))
            0:       lim = 7'd0;
            1:       lim = 7'd1;
            2:       lim = 7'd2;
            3:       lim = 7'd64;
            4:       lim = 7'd127;
            5:       lim = LIMIT_W'($urandom_range(65, 126));
            default: lim = LIMIT_W'($urandom_range(3, 63));
         endcase
         data = $urandom;
         data[LIMIT_W-1:0] = lim;
         write_register(CSR_MAX_ENTRIES, data);
         case ($urandom_range(0, 7))
            0:       data = 32'h0000_0000;
            1:       data = 32'h0000_0001;
            2:       data = 32'hFFFF_FFFF;
            3:       data = RATE_RESET;
            4:       data = $urandom;
            5:       data = $urandom_range(1, 32'h000F_FFFF);
            default: data = $urandom_range(32'h0000_4000, 32'h0010_0000);
         endcase
         write_register(CSR_LINK_RATE, data);
         if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, $urandom);

         case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 55;
            default: enq_pct = 25;
         endcase
         phase_len = $urandom_range(50, 70);

         repeat (phase_len) begin
            wall_time = wall_time + $urandom_range(0, 32'h0004_0000);
            cmd = ($urandom_range(1, 100) <= enq_pct) ? CMD_ENQUEUE : CMD_SWITCH;
            case ($urandom_range(0, 9))
               0:       size = 16'h0000;
               1:       size = 16'hFFFF;
               default: size = SIZE_W'($urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 9))
               0:       arrival = any_time();
               1:       arrival = TIME_MAX - $urandom_range(0, 16'hFFFF);
               2:       arrival = {16'h0, $urandom};
               default: arrival = wall_time;
            endcase
            // switch times aimed around the head entry's ready time
            if (held_count == 0) begin
               now = $urandom_range(0, 1) ? any_time() : wall_time;
            end else begin
               head_ready = held_ready[held_head];
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5: now = head_ready;
                  6, 7, 8, 9:       now = head_ready + $urandom_range(1, 16'hFFFF);
                  10, 11, 12:       now = (head_ready == '0) ? '0 : head_ready - 1;
                  13, 14:           now = TIME_MAX;
                  15, 16:           now = any_time();
                  default:          now = wall_time;
               endcase
            end
            send_word(cmd, TAG_W'($urandom_range(0, 16'hFFFF)), size, arrival, now,
                      1'b0, '0);
            random_sent++;
         end
      end

      // drain
      if (req_up) req_ch.valid <= 1'b0;
      if (csr_up) csr_ch.valid <= 1'b0;
      req_up = 1'b0;
      csr_up = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

      if (errors == 0)
         $display("tb_tail_drop_output_queue_top: PASS");
      else
         $display("tb_tail_drop_output_queue_top: FAIL");
      $finish;
   end

endmodule
